// ===== src/imuaw_pkg.sv =====
`default_nettype none

package imuaw_pkg;

  // Angles are in sixteenths of a degree.
  localparam int FULL_TURN     = 5760;
  localparam int QUARTER_TURN  = 1440;
  localparam int HALF_TURN     = 2880;
  localparam int THREE_QUARTER = 4320;
  localparam int QUARTER_STEPS = 1440;

  // pi in Q2.30
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // Taylor term divisors (2k)(2k+1) for sine and (2k-1)(2k) for cosine.
  localparam longint unsigned SIN_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                              64'd156, 64'd210};
  localparam longint unsigned COS_DIV [7] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                              64'd132, 64'd182};

  typedef logic [63:0] trig_word_t;
  typedef trig_word_t trig_rom_t [QUARTER_STEPS];

  typedef enum logic [1:0] {
    QD_0,
    QD_90,
    QD_180,
    QD_270
  } quadrant_t;

  typedef enum logic [1:0] {
    CFG_JUMP_LIMIT,
    CFG_MAX_REJECTS,
    CFG_LPF_COEFF,
    CFG_STUCK_CODE
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_TRIG,
    S_ROUND,
    S_ROTATE,
    S_FINISH
  } state_t;

  // Rotation sequence: trig products first, then the matrix-vector rows.
  typedef enum logic [4:0] {
    RS_P00, RS_P01, RS_P02, RS_P03, RS_P04, RS_P05, RS_P06, RS_P07,
    RS_P08, RS_P09, RS_P10, RS_P11, RS_P12, RS_P13,
    RS_A00, RS_A01, RS_A02, RS_A10, RS_A11, RS_A12, RS_A20, RS_A21, RS_A22
  } rot_step_t;

  typedef struct packed {
    logic load_in;
    logic take_angle;
    logic lpf_en;
    logic trig_fetch;
    logic trig_round;
  } lane_ctl_t;

  // Sine (upper half) and cosine (lower half) in Q2.30 of an offset in [0, 90) degrees.
  function automatic trig_word_t quarter_trig(input int unsigned a);
    longint unsigned th;
    longint unsigned t2;
    longint unsigned ts;
    longint unsigned tc;
    longint          ss;
    longint          cs;
    th = (64'(a) * PI_Q30) / 64'd2880;
    t2 = (th * th) >> 30;
    ts = th;
    tc = 64'd1 << 30;
    ss = longint'(th);
    cs = longint'(tc);
    for (int k = 1; k <= 7; k++) begin
      ts = ((ts * t2) >> 30) / SIN_DIV[k-1];
      tc = ((tc * t2) >> 30) / COS_DIV[k-1];
      if ((k % 2) == 1) begin
        ss = ss - longint'(ts);
        cs = cs - longint'(tc);
      end else begin
        ss = ss + longint'(ts);
        cs = cs + longint'(tc);
      end
    end
    return {ss[31:0], cs[31:0]};
  endfunction

  function automatic trig_rom_t build_trig_rom();
    trig_rom_t rom;
    for (int i = 0; i < QUARTER_STEPS; i++) begin
      rom[i] = quarter_trig(i);
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

// ===== src/imuaw_lane.sv =====
`default_nettype none

module imuaw_lane import imuaw_pkg::*; #(
  parameter int TRIG_BITS     = 16,
  parameter int LPF_FRAC_BITS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lane_ctl_t                   ctl,
  input  wire logic signed [13:0]          angle,
  input  wire logic signed [15:0]          accel,
  input  wire logic        [12:0]          jump_limit,
  input  wire logic signed [15:0]          stuck_code,
  input  wire logic        [15:0]          coeff,
  output logic                             jump,
  output logic signed [13:0]               held_angle,
  output logic signed [TRIG_BITS:0]        sin_val,
  output logic signed [TRIG_BITS:0]        cos_val,
  output logic signed [LPF_FRAC_BITS+16:0] hp
);

  localparam int LW = LPF_FRAC_BITS + 16;
  localparam int CW = LW + 18;
  localparam logic signed [CW-1:0] LPF_HALF  = CW'(32'sd32768);
  localparam logic signed [32:0]   TRIG_HALF = 33'sd1 <<< (30 - TRIG_BITS);
  localparam trig_rom_t TRIG_ROM = build_trig_rom();

  logic signed [13:0]     angle_new;
  logic signed [15:0]     raw;
  logic signed [13:0]     held;
  logic signed [LW-1:0]   lowpass;
  logic signed [LW:0]     highpass;
  logic        [63:0]     rom_data;
  quadrant_t              quadrant;
  logic signed [TRIG_BITS:0] sine;
  logic signed [TRIG_BITS:0] cosine;

  logic signed [14:0]     diff;
  logic        [14:0]     diff_abs;
  logic signed [LW-1:0]   rf;
  logic signed [LW:0]     delta;
  logic signed [CW-1:0]   prod;
  logic signed [CW-1:0]   step_full;
  logic signed [LW:0]     lp_sum;
  logic signed [LW-1:0]   lp_next;
  logic signed [LW:0]     hp_next;
  logic signed [14:0]     ang_w;
  logic        [12:0]     turn;
  logic        [10:0]     offset;
  quadrant_t              quad_next;
  logic signed [32:0]     qs_w;
  logic signed [32:0]     qc_w;
  logic signed [TRIG_BITS:0] qs;
  logic signed [TRIG_BITS:0] qc;

  // Jump test against the held angle.
  always_comb begin
    diff     = 15'(held) - 15'(angle_new);
    diff_abs = diff[14] ? 15'(-diff) : 15'(diff);
    jump     = diff_abs > 15'(jump_limit);
  end

  // First-order low-pass and the high-pass remainder.
  always_comb begin
    rf        = (raw == stuck_code) ? lowpass : {raw, {LPF_FRAC_BITS{1'b0}}};
    delta     = (LW+1)'(rf) - (LW+1)'(lowpass);
    prod      = CW'(delta) * CW'($signed({1'b0, coeff}));
    step_full = (prod + LPF_HALF) >>> 16;
    lp_sum    = (LW+1)'(lowpass) + (LW+1)'(step_full);
    lp_next   = lp_sum[LW-1:0];
    hp_next   = (LW+1)'(rf) - (LW+1)'(lp_next);
  end

  // Reduce the held angle to a quadrant and an offset within it.
  always_comb begin
    ang_w = 15'(held);
    if (ang_w < 15'sd0) begin
      ang_w = ang_w + 15'(FULL_TURN);
      if (ang_w < 15'sd0) begin
        ang_w = ang_w + 15'(FULL_TURN);
      end
    end else if (ang_w >= 15'(FULL_TURN)) begin
      ang_w = ang_w - 15'(FULL_TURN);
    end
    turn = 13'(ang_w);
    priority if (turn >= 13'(THREE_QUARTER)) begin
      quad_next = QD_270;
      offset    = 11'(turn - 13'(THREE_QUARTER));
    end else if (turn >= 13'(HALF_TURN)) begin
      quad_next = QD_180;
      offset    = 11'(turn - 13'(HALF_TURN));
    end else if (turn >= 13'(QUARTER_TURN)) begin
      quad_next = QD_90;
      offset    = 11'(turn - 13'(QUARTER_TURN));
    end else begin
      quad_next = QD_0;
      offset    = 11'(turn);
    end
  end

  // Round the table values; the quadrant is unfolded when they are registered.
  always_comb begin
    qs_w = (33'($signed(rom_data[63:32])) + TRIG_HALF) >>> (31 - TRIG_BITS);
    qc_w = (33'($signed(rom_data[31:0])) + TRIG_HALF) >>> (31 - TRIG_BITS);
    qs   = (TRIG_BITS+1)'(qs_w);
    qc   = (TRIG_BITS+1)'(qc_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= '0;
      lowpass <= '0;
    end else begin
      if (ctl.take_angle) begin
        held <= angle_new;
      end
      if (ctl.lpf_en) begin
        lowpass <= lp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      angle_new <= angle;
      raw       <= accel;
    end
    if (ctl.lpf_en) begin
      highpass <= hp_next;
    end
    if (ctl.trig_fetch) begin
      rom_data <= TRIG_ROM[offset];
      quadrant <= quad_next;
    end
    if (ctl.trig_round) begin
      unique case (quadrant)
        QD_0: begin
          sine   <= qs;
          cosine <= qc;
        end
        QD_90: begin
          sine   <= qc;
          cosine <= -qs;
        end
        QD_180: begin
          sine   <= -qs;
          cosine <= -qc;
        end
        QD_270: begin
          sine   <= -qc;
          cosine <= qs;
        end
        default: begin
          sine   <= qs;
          cosine <= qc;
        end
      endcase
    end
  end

  assign held_angle = held;
  assign sin_val    = sine;
  assign cos_val    = cosine;
  assign hp         = highpass;

  a_held_only_on_take: assert property (@(posedge clk) disable iff (rst)
    !ctl.take_angle |=> held == $past(held))
    else $error("held angle changed without a take");

endmodule

`default_nettype wire

// ===== src/imuaw_rotate.sv =====
`default_nettype none

module imuaw_rotate import imuaw_pkg::*; #(
  parameter int TRIG_BITS     = 16,
  parameter int LPF_FRAC_BITS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [TRIG_BITS:0]          sx,
  input  wire logic signed [TRIG_BITS:0]          cx,
  input  wire logic signed [TRIG_BITS:0]          sy,
  input  wire logic signed [TRIG_BITS:0]          cy,
  input  wire logic signed [TRIG_BITS:0]          sz,
  input  wire logic signed [TRIG_BITS:0]          cz,
  input  wire logic signed [LPF_FRAC_BITS+16:0]   hp_x,
  input  wire logic signed [LPF_FRAC_BITS+16:0]   hp_y,
  input  wire logic signed [LPF_FRAC_BITS+16:0]   hp_z,
  output logic                                    done,
  output logic signed [15:0]                      world_x,
  output logic signed [15:0]                      world_y,
  output logic signed [15:0]                      world_z
);

  localparam int TW = TRIG_BITS + 2;
  localparam int HW = LPF_FRAC_BITS + 17;
  localparam int BW = (TW > HW) ? TW : HW;
  localparam int PW = TW + BW;
  localparam int AW = PW + 2;
  localparam logic signed [PW-1:0] T_HALF  = PW'(1) <<< (TRIG_BITS - 2);
  localparam logic signed [AW-1:0] W_HALF  = AW'(1) <<< (TRIG_BITS - 2 + LPF_FRAC_BITS);
  localparam logic signed [AW-1:0] SAT_HI  = AW'(32767);
  localparam logic signed [AW-1:0] SAT_LO  = -AW'(32768);

  logic      running;
  rot_step_t step;

  logic signed [TW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [TW-1:0] t3, t9;
  logic signed [AW-1:0] acc0, acc1, acc2;

  logic signed [TW-1:0] op_a;
  logic signed [BW-1:0] op_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_rnd;
  logic signed [TW-1:0] tm;
  logic signed [AW-1:0] pe;

  function automatic logic signed [15:0] finish(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] r;
    r = (a + W_HALF) >>> (TRIG_BITS - 1 + LPF_FRAC_BITS);
    if (r > SAT_HI) begin
      return 16'sh7fff;
    end else if (r < SAT_LO) begin
      return -16'sh8000;
    end
    return 16'(r);
  endfunction

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step)
      RS_P00: begin op_a = TW'(cz); op_b = BW'(cy); end
      RS_P01: begin op_a = TW'(sz); op_b = BW'(cx); end
      RS_P02: begin op_a = TW'(cz); op_b = BW'(sy); end
      RS_P03: begin op_a = t3;      op_b = BW'(sx); end
      RS_P04: begin op_a = TW'(sz); op_b = BW'(sx); end
      RS_P05: begin op_a = t3;      op_b = BW'(cx); end
      RS_P06: begin op_a = TW'(sz); op_b = BW'(cy); end
      RS_P07: begin op_a = TW'(cz); op_b = BW'(cx); end
      RS_P08: begin op_a = TW'(sz); op_b = BW'(sy); end
      RS_P09: begin op_a = t9;      op_b = BW'(sx); end
      RS_P10: begin op_a = TW'(cz); op_b = BW'(sx); end
      RS_P11: begin op_a = t9;      op_b = BW'(cx); end
      RS_P12: begin op_a = TW'(cy); op_b = BW'(sx); end
      RS_P13: begin op_a = TW'(cy); op_b = BW'(cx); end
      RS_A00: begin op_a = m00;     op_b = BW'(hp_x); end
      RS_A01: begin op_a = m01;     op_b = BW'(hp_y); end
      RS_A02: begin op_a = m02;     op_b = BW'(hp_z); end
      RS_A10: begin op_a = m10;     op_b = BW'(hp_x); end
      RS_A11: begin op_a = m11;     op_b = BW'(hp_y); end
      RS_A12: begin op_a = m12;     op_b = BW'(hp_z); end
      RS_A20: begin op_a = m20;     op_b = BW'(hp_x); end
      RS_A21: begin op_a = m21;     op_b = BW'(hp_y); end
      RS_A22: begin op_a = m22;     op_b = BW'(hp_z); end
      default: begin op_a = '0;     op_b = '0; end
    endcase
    prod     = PW'(op_a) * PW'(op_b);
    prod_rnd = (prod + T_HALF) >>> (TRIG_BITS - 1);
    tm       = TW'(prod_rnd);
    pe       = AW'(prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= RS_P00;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= RS_P00;
      end else if (running) begin
        if (step == RS_A22) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          step <= rot_step_t'(step + 5'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (running) begin
      unique case (step)
        RS_P00: begin
          m00 <= tm;
          m20 <= -TW'(sy);
        end
        RS_P01: m01 <= -tm;
        RS_P02: t3  <= tm;
        RS_P03: m01 <= m01 + tm;
        RS_P04: m02 <= tm;
        RS_P05: m02 <= m02 + tm;
        RS_P06: m10 <= tm;
        RS_P07: m11 <= tm;
        RS_P08: t9  <= tm;
        RS_P09: m11 <= m11 + tm;
        RS_P10: m12 <= -tm;
        RS_P11: m12 <= m12 + tm;
        RS_P12: m21 <= tm;
        RS_P13: m22 <= tm;
        RS_A00: acc0 <= pe;
        RS_A01: acc0 <= acc0 + pe;
        RS_A02: acc0 <= acc0 + pe;
        RS_A10: acc1 <= pe;
        RS_A11: acc1 <= acc1 + pe;
        RS_A12: acc1 <= acc1 + pe;
        RS_A20: acc2 <= pe;
        RS_A21: acc2 <= acc2 + pe;
        RS_A22: acc2 <= acc2 + pe;
        default: acc0 <= acc0;
      endcase
    end
  end

  assign world_x = finish(acc0);
  assign world_y = finish(acc1);
  assign world_z = finish(acc2);

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !running)
    else $error("rotation started while busy");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    done |-> !running && $past(step) == RS_A22)
    else $error("rotation done without finishing the sequence");

endmodule

`default_nettype wire

// ===== src/imu_accel_world_frame_filter_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     angle_x/y/z, accel_x/y/z, read_ok
// out       output     out_valid / out_ready   world_accel_x/y/z, held_angle_x/y/z,
//                                              sample_rejected
// cfg       input      cfg_write (no wait)     cfg_index, cfg_data
//
// After acceptance a transaction passes the angle check and low-pass update, the
// sine/cosine table read and rounding, 23 steps of the shared rotation multiplier,
// the hand-back of the finished rotation and the load of the output register.
// A new input transaction is taken only after the previous one has reached the
// output register, as in_ready is raised only in the idle state.
// Reset (rst, synchronous) clears held angles, low-pass state and the reject count
// and restores the register defaults. A new input transaction is taken while a result
// still waits in the output register; the block stalls only when that register is
// still full at the end of the next item.

module imu_accel_world_frame_filter_unit import imuaw_pkg::*; #(
  parameter int TRIG_BITS     = 16,
  parameter int LPF_FRAC_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [13:0] angle_x,
  input  wire logic signed [13:0] angle_y,
  input  wire logic signed [13:0] angle_z,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic signed [15:0] accel_z,
  input  wire logic               read_ok,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      world_accel_x,
  output logic signed [15:0]      world_accel_y,
  output logic signed [15:0]      world_accel_z,
  output logic signed [13:0]      held_angle_x,
  output logic signed [13:0]      held_angle_y,
  output logic signed [13:0]      held_angle_z,
  output logic                    sample_rejected,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  localparam int HW = LPF_FRAC_BITS + 17;

  // Configuration registers; the user must write them only while the block is idle, as the block does not enforce it.
  logic        [12:0] angle_jump_limit;
  logic        [3:0]  max_rejects;
  logic        [15:0] lpf_coeff;
  logic signed [15:0] stuck_accel_code;

  state_t     state, state_next;
  logic [3:0] reject_count;
  logic       read_ok_q;
  logic       rejected;
  lane_ctl_t  lane_ctl;
  logic       rej;
  logic       rot_start;
  logic       rot_done;
  logic       out_load;

  logic signed [13:0]        lane_angle [3];
  logic signed [15:0]        lane_accel [3];
  logic                      lane_jump  [3];
  logic signed [13:0]        lane_held  [3];
  logic signed [TRIG_BITS:0] lane_sin   [3];
  logic signed [TRIG_BITS:0] lane_cos   [3];
  logic signed [HW-1:0]      lane_hp    [3];
  logic signed [15:0]        world_x, world_y, world_z;

  assign lane_angle[0] = angle_x;
  assign lane_angle[1] = angle_y;
  assign lane_angle[2] = angle_z;
  assign lane_accel[0] = accel_x;
  assign lane_accel[1] = accel_y;
  assign lane_accel[2] = accel_z;

  // One lane per axis: jump test, held angle, low-pass filter and trig lookup.
  for (genvar i = 0; i < 3; i++) begin : g_lane
    imuaw_lane #(
      .TRIG_BITS    (TRIG_BITS),
      .LPF_FRAC_BITS(LPF_FRAC_BITS)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (lane_ctl),
      .angle     (lane_angle[i]),
      .accel     (lane_accel[i]),
      .jump_limit(angle_jump_limit),
      .stuck_code(stuck_accel_code),
      .coeff     (lpf_coeff),
      .jump      (lane_jump[i]),
      .held_angle(lane_held[i]),
      .sin_val   (lane_sin[i]),
      .cos_val   (lane_cos[i]),
      .hp        (lane_hp[i])
    );
  end

  // The merging stage: rotate the three high-pass values into the world frame.
  imuaw_rotate #(
    .TRIG_BITS    (TRIG_BITS),
    .LPF_FRAC_BITS(LPF_FRAC_BITS)
  ) u_rotate (
    .clk    (clk),
    .rst    (rst),
    .start  (rot_start),
    .sx     (lane_sin[0]),
    .cx     (lane_cos[0]),
    .sy     (lane_sin[1]),
    .cy     (lane_cos[1]),
    .sz     (lane_sin[2]),
    .cz     (lane_cos[2]),
    .hp_x   (lane_hp[0]),
    .hp_y   (lane_hp[1]),
    .hp_z   (lane_hp[2]),
    .done   (rot_done),
    .world_x(world_x),
    .world_y(world_y),
    .world_z(world_z)
  );

  // A sample is rejected when any axis jumps, the read succeeded and the run of
  // rejects has not yet reached its limit.
  assign rej = (lane_jump[0] || lane_jump[1] || lane_jump[2]) &&
               (reject_count < max_rejects) && read_ok_q;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) begin
                  state_next = S_CHECK;
                end
      S_CHECK:  state_next = S_TRIG;
      S_TRIG:   state_next = S_ROUND;
      S_ROUND:  state_next = S_ROTATE;
      S_ROTATE: if (rot_done) begin
                  state_next = S_FINISH;
                end
      S_FINISH: if (!out_valid || out_ready) begin
                  state_next = S_IDLE;
                end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready            = (state == S_IDLE);
    lane_ctl.load_in    = in_valid && (state == S_IDLE);
    lane_ctl.take_angle = (state == S_CHECK) && !rej;
    lane_ctl.lpf_en     = (state == S_CHECK);
    lane_ctl.trig_fetch = (state == S_TRIG);
    lane_ctl.trig_round = (state == S_ROUND);
    rot_start           = (state == S_ROUND);
    out_load            = (state == S_FINISH) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      reject_count     <= '0;
      out_valid        <= 1'b0;
      angle_jump_limit <= 13'd1440;
      max_rejects      <= 4'd5;
      lpf_coeff        <= 16'd1311;
      stuck_accel_code <= 16'sd128;
    end else begin
      state <= state_next;
      if (state == S_CHECK) begin
        reject_count <= rej ? reject_count + 4'd1 : 4'd0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_JUMP_LIMIT:  angle_jump_limit <= cfg_data[12:0];
          CFG_MAX_REJECTS: max_rejects      <= cfg_data[3:0];
          CFG_LPF_COEFF:   lpf_coeff        <= cfg_data;
          CFG_STUCK_CODE:  stuck_accel_code <= cfg_data;
          default:         lpf_coeff        <= lpf_coeff;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lane_ctl.load_in) begin
      read_ok_q <= read_ok;
    end
    if (state == S_CHECK) begin
      rejected <= rej;
    end
    if (out_load) begin
      world_accel_x   <= world_x;
      world_accel_y   <= world_y;
      world_accel_z   <= world_z;
      held_angle_x    <= lane_held[0];
      held_angle_y    <= lane_held[1];
      held_angle_z    <= lane_held[2];
      sample_rejected <= rejected;
    end
  end

  a_reject_counts_up: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && rej) |=> reject_count == $past(reject_count) + 4'd1)
    else $error("reject count did not advance on a rejected sample");

  a_accept_clears_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && !rej) |=> reject_count == 4'd0)
    else $error("reject count not cleared on an accepted sample");

  a_done_in_rotate: assert property (@(posedge clk) disable iff (rst)
    rot_done |-> state == S_ROTATE)
    else $error("rotation finished outside the rotate state");

endmodule

`default_nettype wire
